// ===== src/zdls_pkg.sv =====
// Shared types and constants for the zone demand leader select block.
package zdls_pkg;

   // Round and field sizing
   localparam int MAX_ZONES    = 16;
   localparam int ITEM_CNT_W   = $clog2(MAX_ZONES + 1);
   localparam int ZONE_W       = 4;
   localparam int CENTI_W      = 15;
   localparam int DEFICIT_W    = 16;
   localparam int CALLERS_W    = 5;
   localparam int TIME_W       = 32;
   localparam int THRESH_W     = 10;
   localparam int STABLE_W     = 22;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 22;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CALL_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STABLE_TIME    = 1'd1;

   // Register reset values
   localparam logic [THRESH_W-1:0] CALL_THRESHOLD_RST = 10'd10;
   localparam logic [STABLE_W-1:0] STABLE_TIME_RST    = 22'd600000;

   // Thermostat demand codes
   localparam logic [1:0] DEMAND_UNKNOWN     = 2'd0;
   localparam logic [1:0] DEMAND_NOT_HEATING = 2'd1;
   localparam logic [1:0] DEMAND_HEATING     = 2'd2;

   // Leader tracking
   localparam logic [ZONE_W:0]      NONE_LEADER = 5'd31;
   localparam logic [CALLERS_W-1:0] CALLERS_MAX = 5'd31;

   typedef struct packed {
      logic [ZONE_W-1:0]         zone_index;
      logic signed [CENTI_W-1:0] room_temp;
      logic                      temp_valid;
      logic signed [CENTI_W-1:0] room_setpoint;
      logic                      setpoint_valid;
      logic [1:0]                demand_state;
      logic                      last_zone;
      logic [TIME_W-1:0]         now_ms;
   } zone_item_type;

endpackage

// ===== src/zone_demand_leader_select.sv =====
// Zone demand leader select: running per-round leader search and learn gate.
// Throughput: one zone transaction per cycle unless a last zone meets a stalled
//   result register, set by the single compare-and-update of the running best
//   between the input and result registers, which a last zone passes in order.
// Reset (synchronous, active high): empties both registers, clears the round,
//   marks no previous leader and loads the register defaults.
module zone_demand_leader_select (
   input  logic                                  clock,
   input  logic                                  reset,
   // zone item channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [zdls_pkg::ZONE_W-1:0]           req_zone_index,
   input  logic signed [zdls_pkg::CENTI_W-1:0]   req_room_temp,
   input  logic                                  req_temp_valid,
   input  logic signed [zdls_pkg::CENTI_W-1:0]   req_room_setpoint,
   input  logic                                  req_setpoint_valid,
   input  logic [1:0]                            req_demand_state,
   input  logic                                  req_last_zone,
   input  logic [zdls_pkg::TIME_W-1:0]           req_now_ms,
   // round result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_leader_found,
   output logic [zdls_pkg::ZONE_W-1:0]           rsp_leader_zone,
   output logic signed [zdls_pkg::CENTI_W-1:0]   rsp_leader_temp,
   output logic signed [zdls_pkg::CENTI_W-1:0]   rsp_leader_setpoint,
   output logic [zdls_pkg::CALLERS_W-1:0]        rsp_caller_count,
   output logic                                  rsp_learn_ok,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [zdls_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [zdls_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // ---------------------------------------------------------------------
   // Config regs: always ready; user writes while the block idles, unenforced.
   // ---------------------------------------------------------------------
   logic [zdls_pkg::THRESH_W-1:0] call_threshold_ff;
   logic [zdls_pkg::STABLE_W-1:0] stable_time_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         call_threshold_ff <= zdls_pkg::CALL_THRESHOLD_RST;
         stable_time_ff    <= zdls_pkg::STABLE_TIME_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            zdls_pkg::REG_CALL_THRESHOLD: begin
               call_threshold_ff <= csr_wdata[zdls_pkg::THRESH_W-1:0];
            end
            zdls_pkg::REG_STABLE_TIME: begin
               stable_time_ff <= csr_wdata[zdls_pkg::STABLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake. A non-last item always retires from the input register;
   // a last item retires only when the result register is free or draining.
   // ---------------------------------------------------------------------
   logic                    item_valid_ff;
   zdls_pkg::zone_item_type item_ff;
   logic                    rsp_valid_ff;
   logic                    out_free;
   logic                    proc_go;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_go   = item_valid_ff && (!item_ff.last_zone || out_free);
   assign req_stall = item_valid_ff && !proc_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   // Payload register: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.zone_index     <= req_zone_index;
         item_ff.room_temp      <= req_room_temp;
         item_ff.temp_valid     <= req_temp_valid;
         item_ff.room_setpoint  <= req_room_setpoint;
         item_ff.setpoint_valid <= req_setpoint_valid;
         item_ff.demand_state   <= req_demand_state;
         item_ff.last_zone      <= req_last_zone;
         item_ff.now_ms         <= req_now_ms;
      end
   end

   // ---------------------------------------------------------------------
   // Running round state.
   // ---------------------------------------------------------------------
   logic [zdls_pkg::ITEM_CNT_W-1:0]          items_ff;
   logic                                     found_ff;
   logic signed [zdls_pkg::DEFICIT_W-1:0]    best_deficit_ff;
   logic [zdls_pkg::ZONE_W-1:0]              leader_ff;
   logic signed [zdls_pkg::CENTI_W-1:0]      leader_temp_ff;
   logic signed [zdls_pkg::CENTI_W-1:0]      leader_setpoint_ff;
   logic [zdls_pkg::CALLERS_W-1:0]           callers_ff;
   logic [zdls_pkg::ZONE_W:0]                prev_leader_ff;
   logic [zdls_pkg::TIME_W-1:0]              leader_since_ff;

   // Values after folding the current item into the round.
   logic                                     item_counted;
   logic signed [zdls_pkg::DEFICIT_W-1:0]    deficit;
   logic signed [zdls_pkg::DEFICIT_W-1:0]    threshold_ext;
   logic                                     calling;
   logic                                     take_lead;
   logic                                     found_in;
   logic [zdls_pkg::ZONE_W-1:0]              leader_in;
   logic signed [zdls_pkg::CENTI_W-1:0]      leader_temp_in;
   logic signed [zdls_pkg::CENTI_W-1:0]      leader_setpoint_in;
   logic signed [zdls_pkg::DEFICIT_W-1:0]    best_deficit_in;
   logic [zdls_pkg::CALLERS_W-1:0]           callers_in;
   logic [zdls_pkg::ITEM_CNT_W-1:0]          items_in;

   // Round-close values.
   logic                                     leader_changed;
   logic [zdls_pkg::TIME_W-1:0]              elapsed;
   logic                                     learn_in;

   assign item_counted =
      (items_ff < zdls_pkg::ITEM_CNT_W'(zdls_pkg::MAX_ZONES));

   // Two 15-bit signed values never overflow a 16-bit difference.
   assign deficit = zdls_pkg::DEFICIT_W'(item_ff.room_setpoint) -
                    zdls_pkg::DEFICIT_W'(item_ff.room_temp);
   assign threshold_ext = $signed({{(zdls_pkg::DEFICIT_W - zdls_pkg::THRESH_W){1'b0}},
                                   call_threshold_ff});

   always_comb begin
      case (item_ff.demand_state)
         zdls_pkg::DEMAND_HEATING:     calling = 1'b1;
         zdls_pkg::DEMAND_NOT_HEATING: calling = 1'b0;
         default:                      calling = (deficit > threshold_ext);
      endcase
      calling = calling && item_counted && item_ff.temp_valid &&
                item_ff.setpoint_valid;
   end

   // Larger deficit wins; an exact tie goes to the lower zone index.
   assign take_lead = calling &&
                      (!found_ff || (deficit > best_deficit_ff) ||
                       ((deficit == best_deficit_ff) && (item_ff.zone_index < leader_ff)));

   assign found_in           = found_ff || calling;
   assign leader_in          = take_lead ? item_ff.zone_index    : leader_ff;
   assign leader_temp_in     = take_lead ? item_ff.room_temp     : leader_temp_ff;
   assign leader_setpoint_in = take_lead ? item_ff.room_setpoint : leader_setpoint_ff;
   assign best_deficit_in    = take_lead ? deficit               : best_deficit_ff;
   assign callers_in = (calling && (callers_ff != zdls_pkg::CALLERS_MAX)) ?
                       callers_ff + 1'b1 : callers_ff;
   assign items_in   = item_counted ? items_ff + 1'b1 : items_ff;

   // A new leader restarts the stability timer at this round's time stamp.
   assign leader_changed = ({1'b0, leader_in} != prev_leader_ff);
   assign elapsed  = leader_changed ? '0 : (item_ff.now_ms - leader_since_ff);
   assign learn_in = found_in &&
                     (elapsed >= {{(zdls_pkg::TIME_W - zdls_pkg::STABLE_W){1'b0}},
                                  stable_time_ff}) &&
                     (callers_in == zdls_pkg::CALLERS_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff        <= '0;
         found_ff        <= 1'b0;
         callers_ff      <= '0;
         prev_leader_ff  <= zdls_pkg::NONE_LEADER;
         leader_since_ff <= '0;
      end else if (proc_go) begin
         if (item_ff.last_zone) begin
            // Close the round: clear running state, track the leader.
            items_ff   <= '0;
            found_ff   <= 1'b0;
            callers_ff <= '0;
            if (!found_in) begin
               prev_leader_ff <= zdls_pkg::NONE_LEADER;
            end else if (leader_changed) begin
               prev_leader_ff  <= {1'b0, leader_in};
               leader_since_ff <= item_ff.now_ms;
            end
         end else begin
            items_ff   <= items_in;
            found_ff   <= found_in;
            callers_ff <= callers_in;
         end
      end
   end

   // Best-so-far payload; only meaningful while found_ff is set.
   always_ff @(posedge clock) begin
      if (proc_go) begin
         best_deficit_ff    <= best_deficit_in;
         leader_ff          <= leader_in;
         leader_temp_ff     <= leader_temp_in;
         leader_setpoint_ff <= leader_setpoint_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: load on round close, drop once taken.
   // ---------------------------------------------------------------------
   logic                                  rsp_found_ff;
   logic [zdls_pkg::ZONE_W-1:0]           rsp_zone_ff;
   logic signed [zdls_pkg::CENTI_W-1:0]   rsp_temp_ff;
   logic signed [zdls_pkg::CENTI_W-1:0]   rsp_setpoint_ff;
   logic [zdls_pkg::CALLERS_W-1:0]        rsp_callers_ff;
   logic                                  rsp_learn_ff;
   logic                                  rsp_load;

   assign rsp_load = proc_go && item_ff.last_zone;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff    <= found_in;
         rsp_zone_ff     <= found_in ? leader_in : '0;
         rsp_temp_ff     <= found_in ? leader_temp_in : '0;
         rsp_setpoint_ff <= found_in ? leader_setpoint_in : '0;
         rsp_callers_ff  <= callers_in;
         rsp_learn_ff    <= learn_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_leader_found    = rsp_found_ff;
   assign rsp_leader_zone     = rsp_zone_ff;
   assign rsp_leader_temp     = rsp_temp_ff;
   assign rsp_leader_setpoint = rsp_setpoint_ff;
   assign rsp_caller_count    = rsp_callers_ff;
   assign rsp_learn_ok        = rsp_learn_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the zone demand leader select block: directed and random rounds, scoreboard.
module tb;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 12;
   // A closing zone passes the input and result registers before its result; leave margin.
   localparam int SETTLE_CYCLES   = 8;
   // Longest legal quiet stretch is the receiver hold-off; the limit is several times that.
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int ZONES_PER_PHASE = 100;

   // Thermostat code outside the defined set; the block treats it as unknown.
   localparam logic [1:0] DEMAND_UNDEFINED = 2'd3;

   typedef struct {
      logic                                found;
      logic [zdls_pkg::ZONE_W-1:0]         zone;
      logic signed [zdls_pkg::CENTI_W-1:0] temp;
      logic signed [zdls_pkg::CENTI_W-1:0] setpoint;
      logic [zdls_pkg::CALLERS_W-1:0]      callers;
      logic                                learn;
   } round_result_type;

   // Running leader search per round, plus the learn timer across rounds.
   class leader_scoreboard;
      logic [zdls_pkg::THRESH_W-1:0]       call_threshold;
      logic [zdls_pkg::STABLE_W-1:0]       stable_time;
      int                                  best_deficit;
      logic                                found;
      logic [zdls_pkg::ZONE_W-1:0]         leader;
      logic signed [zdls_pkg::CENTI_W-1:0] leader_temp;
      logic signed [zdls_pkg::CENTI_W-1:0] leader_setpoint;
      logic [zdls_pkg::CALLERS_W-1:0]      callers;
      logic [zdls_pkg::ZONE_W:0]           prev_leader;
      logic [zdls_pkg::TIME_W-1:0]         leader_since;
      int                                  zones_taken;
      round_result_type                    rounds_due[$];
      int                                  errors;

      function new();
         call_threshold = zdls_pkg::CALL_THRESHOLD_RST;
         stable_time    = zdls_pkg::STABLE_TIME_RST;
         prev_leader    = zdls_pkg::NONE_LEADER;
         leader_since   = '0;
         errors         = 0;
         clear_round();
      endfunction

      function void clear_round();
         best_deficit    = 0;
         found           = 1'b0;
         leader          = '0;
         leader_temp     = '0;
         leader_setpoint = '0;
         callers         = '0;
         zones_taken     = 0;
      endfunction

      function void write_register(logic [zdls_pkg::CSR_INDEX_W-1:0] index,
                                   logic [zdls_pkg::CSR_DATA_W-1:0] data);
         case (index)
            zdls_pkg::REG_CALL_THRESHOLD: call_threshold = data[zdls_pkg::THRESH_W-1:0];
            zdls_pkg::REG_STABLE_TIME:    stable_time    = data[zdls_pkg::STABLE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_zone(zdls_pkg::zone_item_type item);
         int                          deficit;
         logic                        calling;
         logic [zdls_pkg::TIME_W-1:0] elapsed;
         round_result_type            res;
         if (zones_taken < zdls_pkg::MAX_ZONES) begin
            zones_taken++;
            if (item.temp_valid && item.setpoint_valid) begin
               deficit = int'(item.room_setpoint) - int'(item.room_temp);
               if (deficit > 32767) deficit = 32767;
               if (deficit < -32768) deficit = -32768;
               case (item.demand_state)
                  zdls_pkg::DEMAND_HEATING:     calling = 1'b1;
                  zdls_pkg::DEMAND_NOT_HEATING: calling = 1'b0;
                  default:                      calling = deficit > int'(call_threshold);
               endcase
               if (calling) begin
                  if (callers != zdls_pkg::CALLERS_MAX) callers++;
                  if (!found || deficit > best_deficit ||
                      (deficit == best_deficit && item.zone_index < leader)) begin
                     found           = 1'b1;
                     best_deficit    = deficit;
                     leader          = item.zone_index;
                     leader_temp     = item.room_temp;
                     leader_setpoint = item.room_setpoint;
                  end
               end
            end
         end
         if (!item.last_zone) return;
         if (found) begin
            if ({1'b0, leader} != prev_leader) begin
               prev_leader  = {1'b0, leader};
               leader_since = item.now_ms;
            end
            elapsed      = item.now_ms - leader_since;
            res.found    = 1'b1;
            res.zone     = leader;
            res.temp     = leader_temp;
            res.setpoint = leader_setpoint;
            res.learn    = (elapsed >= zdls_pkg::TIME_W'(stable_time)) && (callers == 1);
         end else begin
            prev_leader  = zdls_pkg::NONE_LEADER;
            res.found    = 1'b0;
            res.zone     = '0;
            res.temp     = '0;
            res.setpoint = '0;
            res.learn    = 1'b0;
         end
         res.callers = callers;
         rounds_due.push_back(res);
         clear_round();
      endfunction

      function void compare_field(string name, logic signed [31:0] want_v,
                                  logic signed [31:0] got_v);
         if (got_v !== want_v) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
         end
      endfunction

      function void check_round(round_result_type got);
         round_result_type want;
         if (rounds_due.size() == 0) begin
            errors++;
            $error("round result with no round outstanding");
            return;
         end
         want = rounds_due.pop_front();
         compare_field("leader_found", 32'(want.found), 32'(got.found));
         compare_field("leader_zone", 32'(want.zone), 32'(got.zone));
         compare_field("leader_temp", 32'(want.temp), 32'(got.temp));
         compare_field("leader_setpoint", 32'(want.setpoint), 32'(got.setpoint));
         compare_field("caller_count", 32'(want.callers), 32'(got.callers));
         compare_field("learn_ok", 32'(want.learn), 32'(got.learn));
      endfunction

      function int pending();
         return rounds_due.size();
      endfunction
   endclass

   // Clock, reset and every block input start at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid          = 1'b0;
   logic                                req_stall;
   logic [zdls_pkg::ZONE_W-1:0]         req_zone_index     = '0;
   logic signed [zdls_pkg::CENTI_W-1:0] req_room_temp      = '0;
   logic                                req_temp_valid     = 1'b0;
   logic signed [zdls_pkg::CENTI_W-1:0] req_room_setpoint  = '0;
   logic                                req_setpoint_valid = 1'b0;
   logic [1:0]                          req_demand_state   = zdls_pkg::DEMAND_UNKNOWN;
   logic                                req_last_zone      = 1'b0;
   logic [zdls_pkg::TIME_W-1:0]         req_now_ms         = '0;

   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_leader_found;
   logic [zdls_pkg::ZONE_W-1:0]         rsp_leader_zone;
   logic signed [zdls_pkg::CENTI_W-1:0] rsp_leader_temp;
   logic signed [zdls_pkg::CENTI_W-1:0] rsp_leader_setpoint;
   logic [zdls_pkg::CALLERS_W-1:0]      rsp_caller_count;
   logic                                rsp_learn_ok;

   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [zdls_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [zdls_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   leader_scoreboard rounds_sb = new();

   // Stimulus knobs, changed per phase
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_cycles        = 0;
   int quiet_cycles       = 0;
   int zones_sent;

   // A fixed set of zones that rounds are drawn from, so leaders can persist
   zdls_pkg::zone_item_type     house[zdls_pkg::MAX_ZONES];
   int                          house_start;
   int                          house_step;
   int                          house_size;
   logic [zdls_pkg::TIME_W-1:0] wall_ms;

   zone_demand_leader_select dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // Receiver: hold off for a counted stretch when asked, else stall at random.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Check every accepted round result against the oldest one predicted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         rounds_sb.check_round('{rsp_leader_found, rsp_leader_zone, rsp_leader_temp,
                                 rsp_leader_setpoint, rsp_caller_count, rsp_learn_ok});
   end

   // Watchdog: end the run if no transaction moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic zdls_pkg::zone_item_type make_zone(int zone, int temp, bit tv, int sp,
                                                         bit sv, logic [1:0] demand, bit last,
                                                         logic [zdls_pkg::TIME_W-1:0] now);
      zdls_pkg::zone_item_type item;
      item.zone_index     = zdls_pkg::ZONE_W'(zone);
      item.room_temp      = zdls_pkg::CENTI_W'(temp);
      item.temp_valid     = tv;
      item.room_setpoint  = zdls_pkg::CENTI_W'(sp);
      item.setpoint_valid = sv;
      item.demand_state   = demand;
      item.last_zone      = last;
      item.now_ms         = now;
      return item;
   endfunction

   function automatic int centi_any();
      return int'($urandom_range(0, 15000)) - 5000;
   endfunction

   function automatic logic [1:0] random_demand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return zdls_pkg::DEMAND_UNKNOWN;
         4, 5, 6:    return zdls_pkg::DEMAND_NOT_HEATING;
         7, 8:       return zdls_pkg::DEMAND_HEATING;
         default:    return DEMAND_UNDEFINED;
      endcase
   endfunction

   // Typical room: near 20 degrees, deficit on a coarse grid so ties and
   // exact threshold hits happen often; now and then anything in range.
   function automatic zdls_pkg::zone_item_type random_house_zone(int slot);
      int temp;
      int sp;
      temp = ($urandom_range(0, 9) == 0) ? centi_any() : 1500 + int'($urandom_range(0, 1000));
      sp   = ($urandom_range(0, 9) == 0) ? centi_any()
                                         : temp + 25 * int'($urandom_range(0, 16)) - 100;
      return make_zone(slot, temp, $urandom_range(0, 19) != 0, sp,
                       $urandom_range(0, 19) != 0, random_demand(), 1'b0, '0);
   endfunction

   function automatic zdls_pkg::zone_item_type random_noise();
      return make_zone(int'($urandom_range(0, 15)), centi_any(), 1'($urandom_range(0, 1)),
                       centi_any(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       $urandom_range(0, 4) == 0, $urandom());
   endfunction

   // Offer one zone transaction, idling first at the phase's rate, and hold
   // it until the block takes it.
   task automatic send_zone(zdls_pkg::zone_item_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_zone_index     <= item.zone_index;
      req_room_temp      <= item.room_temp;
      req_temp_valid     <= item.temp_valid;
      req_room_setpoint  <= item.room_setpoint;
      req_setpoint_valid <= item.setpoint_valid;
      req_demand_state   <= item.demand_state;
      req_last_zone      <= item.last_zone;
      req_now_ms         <= item.now_ms;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rounds_sb.note_zone(item);
   endtask

   // Stop offering, let every predicted round come back, then let the
   // pipeline settle so no zone is still in flight.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rounds_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [zdls_pkg::CSR_INDEX_W-1:0] index,
                            logic [zdls_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rounds_sb.write_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One well-formed round drawn from the house: the same walk repeats for a
   // while so a leader can hold long enough to allow learning.
   task automatic play_round();
      zdls_pkg::zone_item_type item;
      int                      slot;
      if ($urandom_range(0, 9) == 0) begin
         house_start = $urandom_range(0, zdls_pkg::MAX_ZONES - 1);
         house_step  = 2 * $urandom_range(0, 7) + 1;
         case ($urandom_range(0, 19))
            0:       house_size = $urandom_range(zdls_pkg::MAX_ZONES + 1,
                                                 zdls_pkg::MAX_ZONES + 3);
            1, 2:    house_size = $urandom_range(7, zdls_pkg::MAX_ZONES);
            default: house_size = $urandom_range(1, 6);
         endcase
      end
      if ($urandom_range(0, 9) < 4) begin
         slot        = $urandom_range(0, zdls_pkg::MAX_ZONES - 1);
         house[slot] = random_house_zone(slot);
      end
      if ($urandom_range(0, 19) == 0)
         for (int s = 0; s < zdls_pkg::MAX_ZONES; s++) house[s] = random_house_zone(s);
      // Advance wall time; an occasional big jump carries it across the wrap.
      case ($urandom_range(0, 19))
         0:             wall_ms += $urandom();
         1, 2, 3, 4, 5: wall_ms += $urandom_range(0, 1000);
         default:       wall_ms += $urandom_range(0, 400000);
      endcase
      for (int i = 0; i < house_size; i++) begin
         slot           = (house_start + i * house_step) % zdls_pkg::MAX_ZONES;
         item           = house[slot];
         item.last_zone = (i == house_size - 1);
         item.now_ms    = item.last_zone ? wall_ms : $urandom();
         send_zone(item);
      end
      // Zones past the round limit are dropped by the block; do not count them.
      zones_sent += (house_size < zdls_pkg::MAX_ZONES) ? house_size : zdls_pkg::MAX_ZONES;
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int threshold, int stable,
                            bit squeeze);
      int pick;
      wait_drained();
      write_csr(zdls_pkg::REG_CALL_THRESHOLD, zdls_pkg::CSR_DATA_W'(threshold));
      write_csr(zdls_pkg::REG_STABLE_TIME, zdls_pkg::CSR_DATA_W'(stable));
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      // Squeeze: hold the result side off while zones keep coming, so the
      // block fills and pushes back on its input.
      if (squeeze) hold_cycles = HOLD_OFF_CYCLES;
      zones_sent = 0;
      while (zones_sent < ZONES_PER_PHASE) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_zone(random_noise());
            zones_sent++;
         end else if (pick < 14) begin
            send_zone(make_zone(0, 0, 1'b0, 0, 1'b0, zdls_pkg::DEMAND_UNKNOWN, 1'b1,
                                wall_ms));
            zones_sent++;
         end else begin
            play_round();
         end
      end
      // Close any round that a noise transaction left open.
      send_zone(make_zone(0, 0, 1'b0, 0, 1'b0, zdls_pkg::DEMAND_UNKNOWN, 1'b1, wall_ms));
   endtask

   // Directed rounds under the register defaults (threshold 10, stable 600000).
   task automatic directed_rounds();
      // Empty round: no leader, previous leader cleared.
      send_zone(make_zone(0, 0, 1'b0, 0, 1'b0, zdls_pkg::DEMAND_UNKNOWN, 1'b1, '0));
      // Threshold edge, undefined demand code, invalid flags, extreme deficit.
      send_zone(make_zone(15, -5000, 1'b1, 10000, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b0, '1));
      send_zone(make_zone(0, 2000, 1'b1, 2010, 1'b1, zdls_pkg::DEMAND_UNKNOWN, 1'b0, '0));
      send_zone(make_zone(1, 2000, 1'b1, 2011, 1'b1, zdls_pkg::DEMAND_UNKNOWN, 1'b0, '0));
      send_zone(make_zone(2, 2000, 1'b1, 2011, 1'b1, DEMAND_UNDEFINED, 1'b0, '0));
      send_zone(make_zone(3, -5000, 1'b1, 10000, 1'b1, zdls_pkg::DEMAND_NOT_HEATING, 1'b0,
                          '0));
      send_zone(make_zone(5, 2000, 1'b1, 2500, 1'b0, zdls_pkg::DEMAND_HEATING, 1'b0, '0));
      send_zone(make_zone(4, 2000, 1'b0, 2500, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'd1000));
      // Equal deficits: the lowest index wins; a negative deficit still calls.
      send_zone(make_zone(7, 1900, 1'b1, 2000, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b0, '0));
      send_zone(make_zone(3, 2100, 1'b1, 2200, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b0, '0));
      send_zone(make_zone(9, 1800, 1'b1, 1900, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b0, '0));
      send_zone(make_zone(3, 2000, 1'b1, 2100, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b0, '0));
      send_zone(make_zone(10, 10000, 1'b1, -5000, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'd2000));
      // Sole caller held just short of, then exactly at, the stable time.
      send_zone(make_zone(6, 2000, 1'b1, 2050, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'd5000));
      send_zone(make_zone(6, 2000, 1'b1, 2050, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'd604999));
      send_zone(make_zone(6, 2000, 1'b1, 2050, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'd605000));
      // Leader change restarts the timer; elapsed time wraps past 2^32.
      send_zone(make_zone(8, 2000, 1'b1, 2080, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'hFFFF_FFF0));
      send_zone(make_zone(8, 2000, 1'b1, 2080, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'hFFFF_FFF0 + 32'd600000));
      // Two callers: no learning even though the leader is stable.
      send_zone(make_zone(2, 2000, 1'b1, 2020, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b0, '0));
      send_zone(make_zone(8, 2000, 1'b1, 2080, 1'b1, zdls_pkg::DEMAND_HEATING, 1'b1,
                          32'hFFFF_FFF0 + 32'd700000));
   endtask

   initial begin
      wall_ms     = '0;
      house_start = 0;
      house_step  = 1;
      house_size  = 4;
      for (int s = 0; s < zdls_pkg::MAX_ZONES; s++) house[s] = random_house_zone(s);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_rounds();

      // Phases: no idling, sender idle, receiver stalling, both, then the squeeze.
      run_phase(0, 0, 0, 0, 1'b0);
      run_phase(57, 0, 1000, 3600000, 1'b0);
      run_phase(0, 57, 25 * $urandom_range(0, 40), $urandom_range(0, 3600000), 1'b0);
      run_phase(20, 20, zdls_pkg::CALL_THRESHOLD_RST, zdls_pkg::STABLE_TIME_RST, 1'b0);
      run_phase(0, 0, 50, 1000, 1'b1);

      wait_drained();
      if (rounds_sb.errors == 0 && rounds_sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== zone_demand_leader_select.f =====
src/zdls_pkg.sv
src/zone_demand_leader_select.sv
tb/tb.sv
